FILE: rtl/core/sars_pkg.sv
// Shared types, constants and helper functions for the SPI converter read sequencer.
`timescale 1ns / 1ps
package sars_pkg;

  localparam int FrameBits = 16;
  localparam int BitCountWidth = $clog2(FrameBits);
  localparam int SampleWidth = 14;
  localparam logic SclkConvClock = 1'b0;

  localparam logic [3:0] CmdInit = 4'hA;
  localparam logic [3:0] CmdRead = 4'hE;
  localparam logic [3:0] ChanRefA = 4'h8;
  localparam logic [3:0] ChanRefB = 4'h9;
  localparam logic [3:0] ChanRefC = 4'hA;
  localparam logic [3:0] CodeRefA = 4'hC;
  localparam logic [3:0] CodeRefB = 4'hB;
  localparam logic [3:0] CodeRefC = 4'hD;

  localparam int AddrWidth = 5;
  localparam logic [2:0] RegRefExternal = 3'd0;
  localparam logic [2:0] RegTwosComplement = 3'd1;
  localparam logic [2:0] RegShortSample = 3'd2;
  localparam logic [2:0] RegPseudoDiff = 3'd3;
  localparam logic [2:0] RegConvMode = 3'd4;
  localparam logic [2:0] RegSweepSeq = 3'd5;
  localparam logic [2:0] RegEocPin = 3'd6;
  localparam logic [2:0] RegTriggerLevel = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CSH,
    PH_CSL,
    PH_DAT,
    PH_CKH,
    PH_CKL,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [3:0] code;
    logic       sdi;
  } tick_t;

  typedef struct packed {
    logic                   cs;
    logic                   clk;
    logic                   dat;
    logic                   busy;
    logic                   valid;
    logic [SampleWidth-1:0] data;
  } res_t;

  typedef struct packed {
    logic       ref_external;
    logic       twos_complement;
    logic       short_sample;
    logic       pseudo_diff;
    logic [1:0] conv_mode;
    logic [1:0] sweep_seq;
    logic       eoc_pin;
    logic [1:0] trigger_level;
  } cfg_t;

  function automatic logic [3:0] channel_code(input logic [3:0] ch);
    logic [3:0] code;
    code = ch;
    if (ch == ChanRefA) begin
      code = CodeRefA;
    end else if (ch == ChanRefB) begin
      code = CodeRefB;
    end else if (ch == ChanRefC) begin
      code = CodeRefC;
    end
    return code;
  endfunction

  function automatic logic [FrameBits-1:0] packed_config(input cfg_t c);
    return {CmdInit, c.ref_external, c.twos_complement, c.short_sample, SclkConvClock,
            c.pseudo_diff, c.conv_mode, c.sweep_seq, c.eoc_pin, c.trigger_level};
  endfunction

endpackage

FILE: rtl/core/spi_adc_read_sequencer.sv
// Top level of the SPI converter read sequencer with its configuration registers.
// Items pass the input queue, the single-step pin sequencer and the output queue.
// Throughput: one item per cycle while the output queue is not full.
// Each item is one pin phase and yields exactly one result.
// Reset empties both queues, puts the sequencer in idle with chip select high,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
module spi_adc_read_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_valid,
  input  logic                           req_type,
  input  logic [3:0]                     channel,
  input  logic                           serial_data_in,
  output logic                           empty,
  input  logic                           pop,
  output logic                           chip_select_high,
  output logic                           serial_clock,
  output logic                           serial_data_out,
  output logic                           busy_res,
  output logic                           sample_valid,
  output logic [sars_pkg::SampleWidth-1:0] sample_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sars_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sars_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] reg_index;
  tick_t      tick;
  logic       tick_avail;
  logic       tick_take;
  res_t       res;
  res_t       res_head;
  logic       res_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_index = paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_external <= 1'b1;
      cfg.twos_complement <= 1'b0;
      cfg.short_sample <= 1'b1;
      cfg.pseudo_diff <= 1'b0;
      cfg.conv_mode <= 2'd0;
      cfg.sweep_seq <= 2'd0;
      cfg.eoc_pin <= 1'b1;
      cfg.trigger_level <= 2'd2;
    end else if (cfg_wr) begin
      case (reg_index)
        RegRefExternal:    cfg.ref_external <= pwdata[0];
        RegTwosComplement: cfg.twos_complement <= pwdata[0];
        RegShortSample:    cfg.short_sample <= pwdata[0];
        RegPseudoDiff:     cfg.pseudo_diff <= pwdata[0];
        RegConvMode:       cfg.conv_mode <= pwdata[1:0];
        RegSweepSeq:       cfg.sweep_seq <= pwdata[1:0];
        RegEocPin:         cfg.eoc_pin <= pwdata[0];
        RegTriggerLevel:   cfg.trigger_level <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      RegRefExternal:    prdata = {31'd0, cfg.ref_external};
      RegTwosComplement: prdata = {31'd0, cfg.twos_complement};
      RegShortSample:    prdata = {31'd0, cfg.short_sample};
      RegPseudoDiff:     prdata = {31'd0, cfg.pseudo_diff};
      RegConvMode:       prdata = {30'd0, cfg.conv_mode};
      RegSweepSeq:       prdata = {30'd0, cfg.sweep_seq};
      RegEocPin:         prdata = {31'd0, cfg.eoc_pin};
      RegTriggerLevel:   prdata = {30'd0, cfg.trigger_level};
      default:           prdata = 32'd0;
    endcase
  end

  sars_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_valid      (req_valid),
    .req_type       (req_type),
    .channel        (channel),
    .serial_data_in (serial_data_in),
    .tick_avail     (tick_avail),
    .tick_take      (tick_take),
    .tick           (tick)
  );

  sars_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_avail (tick_avail),
    .tick       (tick),
    .tick_take  (tick_take),
    .res_full   (res_full),
    .res        (res)
  );

  sars_back_buf u_back_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tick_take),
    .wr_item (res),
    .full    (res_full),
    .empty   (empty),
    .pop     (pop),
    .rd_item (res_head)
  );

  assign chip_select_high = res_head.cs;
  assign serial_clock = res_head.clk;
  assign serial_data_out = res_head.dat;
  assign busy_res = res_head.busy;
  assign sample_valid = res_head.valid;
  assign sample_data = res_head.data;

endmodule

FILE: rtl/core/sars_front.sv
// Input queue that accepts ticks and decodes the channel select code.
`timescale 1ns / 1ps
module sars_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          req_valid,
  input  logic          req_type,
  input  logic [3:0]    channel,
  input  logic          serial_data_in,
  output logic          tick_avail,
  input  logic          tick_take,
  output sars_pkg::tick_t tick
);
  import sars_pkg::*;

  tick_t      slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       wr_en;
  tick_t      incoming;

  assign full = (count == 2'd2);
  assign wr_en = push && !full;
  assign tick_avail = (count != 2'd0);
  assign tick = slot[rd_ptr];

  always_comb begin
    incoming.req_valid = req_valid;
    incoming.req_type = req_type;
    incoming.code = channel_code(channel);
    incoming.sdi = serial_data_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count + {1'b0, wr_en} - {1'b0, tick_take};
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (tick_take) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule

FILE: rtl/core/sars_seq.sv
// Pin sequencer that advances one pin phase for each tick it takes, once a request starts.
`timescale 1ns / 1ps
module sars_seq (
  input  logic            clk,
  input  logic            rst,
  input  sars_pkg::cfg_t  cfg,
  input  logic            tick_avail,
  input  sars_pkg::tick_t tick,
  output logic            tick_take,
  input  logic            res_full,
  output sars_pkg::res_t  res
);
  import sars_pkg::*;

  localparam logic [BitCountWidth-1:0] LastBit = BitCountWidth'(FrameBits - 1);

  phase_t                   phase;
  phase_t                   phase_next;
  logic [BitCountWidth-1:0] bit_count;
  logic [BitCountWidth-1:0] bit_count_next;
  logic                     frame_index;
  logic                     frame_index_next;
  logic                     request_kind;
  logic                     request_kind_next;
  logic [FrameBits-1:0]     shift_out;
  logic [FrameBits-1:0]     shift_out_next;
  logic [FrameBits-1:0]     shift_in;
  logic [FrameBits-1:0]     shift_in_next;
  logic                     pin_cs;
  logic                     pin_clk;
  logic                     pin_dat;
  logic [BitCountWidth-1:0] bit_inc;

  assign tick_take = tick_avail && !res_full;
  assign bit_inc = bit_count + 1'b1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (tick.req_valid) begin
          phase_next = PH_CSH;
        end
      end
      PH_CSH: phase_next = PH_CSL;
      PH_CSL: phase_next = PH_DAT;
      PH_DAT: phase_next = PH_CKH;
      PH_CKH: phase_next = PH_CKL;
      PH_CKL: begin
        if (bit_count != LastBit) begin
          phase_next = PH_DAT;
        end else if (!frame_index) begin
          phase_next = PH_GAP;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_GAP: phase_next = PH_CSH;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    bit_count_next = bit_count;
    frame_index_next = frame_index;
    request_kind_next = request_kind;
    shift_out_next = shift_out;
    shift_in_next = shift_in;
    res.cs = pin_cs;
    res.clk = pin_clk;
    res.dat = pin_dat;
    res.busy = 1'b1;
    res.valid = 1'b0;
    res.data = '0;
    case (phase)
      PH_IDLE: begin
        res.cs = 1'b1;
        res.clk = 1'b0;
        res.dat = 1'b0;
        if (tick.req_valid) begin
          request_kind_next = tick.req_type;
          frame_index_next = 1'b0;
          bit_count_next = '0;
          shift_in_next = '0;
          shift_out_next = tick.req_type ? {tick.code, 12'h000} : {CmdInit, 12'h000};
        end else begin
          res.busy = 1'b0;
        end
      end
      PH_CSH: begin
        res.cs = 1'b0;
        res.clk = 1'b0;
        res.dat = 1'b0;
      end
      PH_CSL: begin
        res.cs = 1'b0;
        res.clk = 1'b0;
        res.dat = shift_out[LastBit - bit_count];
      end
      PH_DAT: begin
        res.clk = 1'b1;
      end
      PH_CKH: begin
        res.clk = 1'b0;
        if (tick.sdi) begin
          shift_in_next[LastBit - bit_count] = 1'b1;
        end
      end
      PH_CKL: begin
        if (bit_count != LastBit) begin
          bit_count_next = bit_inc;
          res.cs = 1'b0;
          res.clk = 1'b0;
          res.dat = shift_out[LastBit - bit_inc];
        end else begin
          res.cs = 1'b1;
          res.clk = 1'b0;
          res.dat = 1'b0;
          if (frame_index && request_kind) begin
            res.valid = 1'b1;
            res.data = shift_in[FrameBits-1:2];
          end
        end
      end
      PH_GAP: begin
        frame_index_next = 1'b1;
        bit_count_next = '0;
        shift_in_next = '0;
        shift_out_next = request_kind ? {CmdRead, 12'h000} : packed_config(cfg);
        res.cs = 1'b1;
        res.clk = 1'b0;
        res.dat = 1'b0;
      end
      default: begin
        res.cs = 1'b1;
        res.clk = 1'b0;
        res.dat = 1'b0;
        res.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= '0;
      frame_index <= 1'b0;
      request_kind <= 1'b0;
      shift_out <= '0;
      shift_in <= '0;
      pin_cs <= 1'b1;
      pin_clk <= 1'b0;
      pin_dat <= 1'b0;
    end else if (tick_take) begin
      phase <= phase_next;
      bit_count <= bit_count_next;
      frame_index <= frame_index_next;
      request_kind <= request_kind_next;
      shift_out <= shift_out_next;
      shift_in <= shift_in_next;
      pin_cs <= res.cs;
      pin_clk <= res.clk;
      pin_dat <= res.dat;
    end
  end

endmodule

FILE: rtl/core/sars_back_buf.sv
// Output queue that holds finished results until they are popped.
`timescale 1ns / 1ps
module sars_back_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  sars_pkg::res_t wr_item,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output sars_pkg::res_t rd_item
);
  import sars_pkg::*;

  res_t       slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       rd_en;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_en = pop && !empty;
  assign rd_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the SPI converter read sequencer, driven one pin tick per item.
`timescale 1ns / 1ps
module testbench;
  import sars_pkg::*;

  localparam logic ReqInit = 1'b0;
  localparam logic ReqRead = 1'b1;
  localparam int MaxGap = 13;
  localparam int HoldCycles = 300;
  localparam int RandomItems = 300;
  localparam int CycleLimit = 200000;

  typedef enum {SDI_LOW, SDI_HIGH, SDI_RANDOM} sdi_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic req_valid = 1'b0;
  logic req_type = 1'b0;
  logic [3:0] channel = '0;
  logic serial_data_in = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic chip_select_high;
  logic serial_clock;
  logic serial_data_out;
  logic busy_res;
  logic sample_valid;
  logic [SampleWidth-1:0] sample_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  spi_adc_read_sequencer i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_valid(req_valid), .req_type(req_type), .channel(channel),
    .serial_data_in(serial_data_in), .empty(empty), .pop(pop),
    .chip_select_high(chip_select_high), .serial_clock(serial_clock),
    .serial_data_out(serial_data_out), .busy_res(busy_res),
    .sample_valid(sample_valid), .sample_data(sample_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the sequencer state and its configuration registers.
  phase_t seq_phase = PH_IDLE;
  logic [3:0] bit_idx = '0;
  logic second_frame = 1'b0;
  logic is_read = 1'b0;
  logic [FrameBits-1:0] tx_word = '0;
  logic [FrameBits-1:0] rx_word = '0;
  logic pin_cs = 1'b1;
  logic pin_sck = 1'b0;
  logic pin_sdo = 1'b0;
  cfg_t cfg_mirror = '{ref_external: 1'b1, twos_complement: 1'b0, short_sample: 1'b1,
                       pseudo_diff: 1'b0, conv_mode: 2'd0, sweep_seq: 2'd0,
                       eoc_pin: 1'b1, trigger_level: 2'd2};

  res_t predicted_ticks[$];
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold_req = 1'b0;
  int mismatch_count = 0;
  int items_sent = 0;
  int requests_started = 0;
  int samples_seen = 0;
  int config_writes = 0;

  function automatic logic [FrameBits-1:0] select_word(input logic [3:0] ch);
    logic [3:0] code;
    case (ch)
      ChanRefA: code = CodeRefA;
      ChanRefB: code = CodeRefB;
      ChanRefC: code = CodeRefC;
      default: code = ch;
    endcase
    return {code, 12'h000};
  endfunction

  function automatic logic [FrameBits-1:0] setup_word();
    logic [FrameBits-1:0] w;
    w = {CmdInit, 12'h000};
    w[11] = cfg_mirror.ref_external;
    w[10] = cfg_mirror.twos_complement;
    w[9] = cfg_mirror.short_sample;
    w[8] = SclkConvClock;
    w[7] = cfg_mirror.pseudo_diff;
    w[6:5] = cfg_mirror.conv_mode;
    w[4:3] = cfg_mirror.sweep_seq;
    w[2] = cfg_mirror.eoc_pin;
    w[1:0] = cfg_mirror.trigger_level;
    return w;
  endfunction

  function automatic res_t advance_sequencer(input logic rv, input logic rt,
                                             input logic [3:0] ch, input logic sdi);
    res_t r;
    r = '0;
    r.busy = 1'b1;
    case (seq_phase)
      PH_IDLE: begin
        {pin_cs, pin_sck, pin_sdo} = 3'b100;
        if (rv) begin
          is_read = rt;
          second_frame = 1'b0;
          bit_idx = '0;
          rx_word = '0;
          tx_word = rt ? select_word(ch) : {CmdInit, 12'h000};
          seq_phase = PH_CSH;
          requests_started++;
        end else begin
          r.busy = 1'b0;
        end
      end
      PH_CSH: begin
        {pin_cs, pin_sck, pin_sdo} = 3'b000;
        seq_phase = PH_CSL;
      end
      PH_CSL: begin
        {pin_cs, pin_sck, pin_sdo} = {2'b00, tx_word[FrameBits - 1 - bit_idx]};
        seq_phase = PH_DAT;
      end
      PH_DAT: begin
        pin_sck = 1'b1;
        seq_phase = PH_CKH;
      end
      PH_CKH: begin
        pin_sck = 1'b0;
        if (sdi) begin
          rx_word[FrameBits - 1 - bit_idx] = 1'b1;
        end
        seq_phase = PH_CKL;
      end
      PH_CKL: begin
        if (bit_idx < FrameBits - 1) begin
          bit_idx = bit_idx + 1'b1;
          {pin_cs, pin_sck, pin_sdo} = {2'b00, tx_word[FrameBits - 1 - bit_idx]};
          seq_phase = PH_DAT;
        end else begin
          {pin_cs, pin_sck, pin_sdo} = 3'b100;
          if (!second_frame) begin
            seq_phase = PH_GAP;
          end else begin
            seq_phase = PH_IDLE;
            if (is_read) begin
              r.valid = 1'b1;
              r.data = rx_word[FrameBits-1:2];
              samples_seen++;
            end
          end
        end
      end
      default: begin
        second_frame = 1'b1;
        bit_idx = '0;
        rx_word = '0;
        tx_word = is_read ? {CmdRead, 12'h000} : setup_word();
        {pin_cs, pin_sck, pin_sdo} = 3'b100;
        seq_phase = PH_CSH;
      end
    endcase
    r.cs = pin_cs;
    r.clk = pin_sck;
    r.dat = pin_sdo;
    return r;
  endfunction

  function automatic logic sdi_bit(input sdi_pattern_t p);
    case (p)
      SDI_LOW: return 1'b0;
      SDI_HIGH: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic rv, input logic rt, input logic [3:0] ch,
                           input logic sdi);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxGap) : 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    req_valid <= rv;
    req_type <= rt;
    channel <= ch;
    serial_data_in <= sdi;
    do @(posedge clk); while (full);
    predicted_ticks.push_back(advance_sequencer(rv, rt, ch, sdi));
    items_sent++;
  endtask

  // Runs one request to completion; busy_pct sets how often a new request is
  // offered while the sequence is still running.
  task automatic run_request(input logic rt, input logic [3:0] ch, input sdi_pattern_t p,
                             input int busy_pct);
    send_tick(1'b1, rt, ch, sdi_bit(p));
    while (seq_phase != PH_IDLE) begin
      send_tick($urandom_range(0, 99) < busy_pct, 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), sdi_bit(p));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (predicted_ticks.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    logic [2:0] idx;
    logic [31:0] val;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(k);
      case (idx)
        RegRefExternal: val = 32'(c.ref_external);
        RegTwosComplement: val = 32'(c.twos_complement);
        RegShortSample: val = 32'(c.short_sample);
        RegPseudoDiff: val = 32'(c.pseudo_diff);
        RegConvMode: val = 32'(c.conv_mode);
        RegSweepSeq: val = 32'(c.sweep_seq);
        RegEocPin: val = 32'(c.eoc_pin);
        default: val = 32'(c.trigger_level);
      endcase
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      config_writes++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_mirror = c;
  endtask

  function automatic cfg_t random_config();
    logic [10:0] bits;
    bits = 11'($urandom);
    return cfg_t'(bits);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  initial begin : result_checker
    int stall;
    res_t want;
    wait (!rst);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MaxGap) : 0;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HoldCycles;
      end
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (predicted_ticks.size() == 0) begin
        mismatch_count++;
        $error("Result item popped while no result was expected.");
      end else begin
        want = predicted_ticks.pop_front();
        check_field("chip_select_high", 16'(want.cs), 16'(chip_select_high));
        check_field("serial_clock", 16'(want.clk), 16'(serial_clock));
        check_field("serial_data_out", 16'(want.dat), 16'(serial_data_out));
        check_field("busy_res", 16'(want.busy), 16'(busy_res));
        check_field("sample_valid", 16'(want.valid), 16'(sample_valid));
        check_field("sample_data", 16'(want.data), 16'(sample_data));
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic test_idle_ticks();
    send_tick(1'b0, ReqRead, 4'hF, 1'b1);
    send_tick(1'b0, ReqInit, 4'h0, 1'b0);
    send_tick(1'b0, ReqRead, 4'h5, 1'b1);
  endtask

  task automatic test_init_defaults();
    run_request(ReqInit, 4'h0, SDI_HIGH, 0);
  endtask

  task automatic test_channel_map();
    logic [3:0] chans[7] = '{4'd0, 4'd7, ChanRefA, ChanRefB, ChanRefC, 4'd11, 4'd15};
    foreach (chans[i]) begin
      run_request(ReqRead, chans[i], sdi_pattern_t'(i % 3), 0);
    end
  endtask

  task automatic test_requests_while_busy();
    run_request(ReqRead, 4'd5, SDI_RANDOM, 100);
    run_request(ReqInit, 4'd3, SDI_RANDOM, 100);
  endtask

  task automatic test_config_extremes();
    drain_results();
    set_config('0);
    run_request(ReqInit, 4'd0, SDI_LOW, 0);
    drain_results();
    set_config('1);
    run_request(ReqInit, 4'd0, SDI_HIGH, 0);
    run_request(ReqRead, 4'd2, SDI_RANDOM, 0);
  endtask

  // The setup word is built from the registers as they stand when the second
  // frame opens, so a write during the first frame must show up in it.
  task automatic test_config_mid_init();
    send_tick(1'b1, ReqInit, 4'd0, 1'b0);
    repeat (20) send_tick(1'b0, ReqInit, 4'd0, 1'($urandom_range(0, 1)));
    drain_results();
    set_config(random_config());
    while (seq_phase != PH_IDLE) begin
      send_tick(1'b0, ReqInit, 4'd0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    run_request(ReqRead, 4'd9, SDI_RANDOM, 0);
    run_request(ReqRead, 4'd6, SDI_RANDOM, 20);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      pick = $urandom_range(0, 99);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (pick < 8) begin
        drain_results();
        set_config(random_config());
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        run_request($urandom_range(0, 9) < 7, 4'($urandom_range(0, 15)),
                    sdi_pattern_t'($urandom_range(0, 2)),
                    ($urandom_range(0, 3) == 0) ? 30 : 0);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_config(cfg_mirror);
    test_idle_ticks();
    test_init_defaults();
    test_channel_map();
    test_requests_while_busy();
    test_config_extremes();
    test_config_mid_init();
    test_backpressure();
    test_random();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d pin ticks covering %0d init and read requests, %0d samples returned.",
             items_sent, requests_started, samples_seen);
    $display("Wrote %0d configuration registers; %0d field mismatches seen.",
             config_writes, mismatch_count);
    if (mismatch_count == 0 && predicted_ticks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sars_pkg.sv
rtl/core/sars_front.sv
rtl/core/sars_seq.sv
rtl/core/sars_back_buf.sv
rtl/core/spi_adc_read_sequencer.sv
verif/testbench.sv
